/* hw/rtl/lis_pkg.sv */
// Shared types and constants for the LIS-length block.
// No dependencies; compiled first.
`default_nettype none
package lis_pkg;
  localparam int RUN_LEN_W = 11;
  localparam int POS_W     = 10;

  typedef logic [RUN_LEN_W-1:0] run_len_t;
  typedef logic [POS_W-1:0]     pos_t;
endpackage
`default_nettype wire

/* hw/rtl/lis_if.sv */
// Valid/ready channel interfaces for the LIS-length block.
// Depends on lis_pkg.
`default_nettype none
interface lis_in_if #(parameter int VALUE_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] sample_value;
  logic                  start_sequence;

  modport source (output valid, sample_value, start_sequence, input ready);
  modport sink   (input valid, sample_value, start_sequence, output ready);
endinterface

interface lis_out_if;
  import lis_pkg::*;
  logic     valid;
  logic     ready;
  run_len_t run_length;
  pos_t     position;
  logic     overflow;

  modport source (output valid, run_length, position, overflow, input ready);
  modport sink   (input valid, run_length, position, overflow, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lis_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/lis_length_ending_at_each.sv */
// LIS length ending at each value: scans all earlier stored values of the sequence.
// Each item is handled in order: one RAM read per stored predecessor, a drain step, a finish
// step that registers the result and, unless overflowed, stores the item, then idle.
// Overflow and first items go straight from idle to the finish step; in_ch.ready is high only in idle.
// A result held by out_ch.ready stalls the finish step. The RAM read port sets the rate.
// Synchronous active-low reset clears the sequencer, item count and output valid;
// store contents are undefined until written.
`default_nettype none
module lis_length_ending_at_each #(
  parameter int MAX_LEN    = 1024,
  parameter int VALUE_BITS = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  lis_in_if.sink   in_ch,
  lis_out_if.source out_ch
);
  import lis_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int LW = CW;
  localparam int WW = VALUE_BITS + LW;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         rd_idx_r, rd_idx_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [LW-1:0]         best_r, best_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [CW-1:0]         item_count_r, item_count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  run_len_t              out_len_r, out_len_nxt;
  pos_t                  out_pos_r, out_pos_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic                  ram_we, ram_re;
  logic [WW-1:0]         ram_rdata;
  logic [VALUE_BITS-1:0] rd_value;
  logic [LW-1:0]         rd_len, cand;
  logic [CW-1:0]         cnt_in;
  logic [31:0]           best_ext, pos_ext;

  assign rd_value = ram_rdata[WW-1:LW];
  assign rd_len   = ram_rdata[LW-1:0];
  assign cand     = rd_len + LW'(1);
  assign cnt_in   = in_ch.start_sequence ? '0 : item_count_r;
  assign best_ext = 32'(best_r);
  assign pos_ext  = 32'(cnt_r);

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.run_length = out_len_r;
  assign out_ch.position   = out_pos_r;
  assign out_ch.overflow   = out_ovf_r;

  lis_ram #(.WIDTH(WW), .DEPTH(MAX_LEN)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata ({key_r, best_r}),
    .re    (ram_re),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    cnt_nxt        = cnt_r;
    rd_idx_nxt     = rd_idx_r;
    rd_pend_nxt    = 1'b0;
    best_nxt       = best_r;
    ovf_nxt        = ovf_r;
    item_count_nxt = item_count_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_len_nxt    = out_len_r;
    out_pos_nxt    = out_pos_r;
    out_ovf_nxt    = out_ovf_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    if (rd_pend_r && ($signed(key_r) > $signed(rd_value)) && (cand > best_r)) begin
      best_nxt = cand;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          key_nxt    = in_ch.sample_value;
          cnt_nxt    = cnt_in;
          rd_idx_nxt = '0;
          best_nxt   = LW'(1);
          ovf_nxt    = (cnt_in == CW'(MAX_LEN));
          if (cnt_in == '0 || cnt_in == CW'(MAX_LEN)) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        ram_re      = 1'b1;
        rd_pend_nxt = 1'b1;
        rd_idx_nxt  = rd_idx_r + CW'(1);
        if (rd_idx_r == cnt_r - CW'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_ovf_nxt   = ovf_r;
          if (ovf_r) begin
            out_len_nxt = '0;
            out_pos_nxt = '0;
          end else begin
            out_len_nxt    = best_ext[RUN_LEN_W-1:0];
            out_pos_nxt    = pos_ext[POS_W-1:0];
            ram_we         = 1'b1;
            item_count_nxt = cnt_r + CW'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_pend_r    <= 1'b0;
      item_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_pend_r    <= rd_pend_nxt;
      item_count_r <= item_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    key_r     <= key_nxt;
    cnt_r     <= cnt_nxt;
    rd_idx_r  <= rd_idx_nxt;
    best_r    <= best_nxt;
    ovf_r     <= ovf_nxt;
    out_len_r <= out_len_nxt;
    out_pos_r <= out_pos_nxt;
    out_ovf_r <= out_ovf_nxt;
  end
endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for lis_length_ending_at_each: queued stimulus, a falling-edge driver,
// a rising-edge monitor with an in-order LIS predictor, and a no-progress watchdog.
// Depends on lis_pkg, the lis_in_if / lis_out_if interfaces and lis_length_ending_at_each.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lis_pkg::*;

  localparam int MAX_LEN       = 1024;
  localparam int VALUE_BITS    = 32;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 8000;
  localparam int DRAIN_CYCLES  = 64;
  localparam int LONG_RUN      = 200;
  localparam int PHASE_ITEMS   = 72;
  localparam logic [31:0] VAL_MIN = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;

  typedef enum logic [2:0] {
    PH_NO_IDLE,
    PH_SRC_IDLE,
    PH_SNK_STALL,
    PH_BOTH_IDLE,
    PH_HOLD
  } phase_t;

  typedef struct {
    logic [VALUE_BITS-1:0] sample_value;
    logic                  start_sequence;
  } lis_item_t;

  typedef struct {
    run_len_t run_length;
    pos_t     position;
    logic     overflow;
  } lis_result_t;

  logic clk;
  logic rst_n;

  lis_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch ();
  lis_out_if out_ch ();

  lis_length_ending_at_each #(
    .MAX_LEN   (MAX_LEN),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  lis_item_t   lis_pending[$];
  lis_result_t lis_expected[$];

  // predictor state
  logic signed [VALUE_BITS-1:0] seq_values[MAX_LEN];
  run_len_t                     seq_lengths[MAX_LEN];
  int unsigned                  seq_count;

  phase_t cur_phase;
  logic   in_took;
  int     hold_cycles;
  int     stall_cycles;
  int     mismatches;
  int     gen_count;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic predict_lis_step(input logic signed [VALUE_BITS-1:0] v, input logic first,
                                  output lis_result_t r);
    int unsigned best;
    int unsigned j;
    best = 1;
    if (first) seq_count = 0;
    if (seq_count >= MAX_LEN) begin
      r.run_length = '0;
      r.position   = '0;
      r.overflow   = 1'b1;
    end else begin
      for (j = 0; j < seq_count; j++) begin
        if (v > seq_values[j] && int'(seq_lengths[j]) + 1 > best) best = seq_lengths[j] + 1;
      end
      seq_values[seq_count]  = v;
      seq_lengths[seq_count] = run_len_t'(best);
      r.run_length = run_len_t'(best);
      r.position   = pos_t'(seq_count);
      r.overflow   = 1'b0;
      seq_count++;
    end
  endtask

  task automatic queue_item(input logic [VALUE_BITS-1:0] v, input logic first);
    lis_item_t it;
    it.sample_value   = v;
    it.start_sequence = first;
    lis_pending.push_back(it);
    gen_count = first ? 1 : gen_count + 1;
  endtask

  // Short sequences with random content; some continue the previous one without a start flag.
  task automatic queue_random_sequences(input int n_items);
    int made, len, kind, j;
    logic cont;
    logic [VALUE_BITS-1:0] v, base;
    made = 0;
    while (made < n_items) begin
      len  = ($urandom_range(9) == 0) ? int'($urandom_range(64, 30)) : int'($urandom_range(20, 1));
      cont = ($urandom_range(5) == 0) && (gen_count + len < 300);
      kind = $urandom_range(4);
      base = $urandom;
      for (j = 0; j < len; j++) begin
        case (kind)
          0: v = int'($urandom_range(12)) - 6;
          1: v = $urandom;
          2: begin
            base = base + int'($urandom_range(3)) - 1;
            v = base;
          end
          3: v = $urandom_range(1) ? VAL_MIN + $urandom_range(3) : VAL_MAX - $urandom_range(3);
          default: v = $urandom_range(1) ? $urandom : int'($urandom_range(8)) - 4;
        endcase
        queue_item(v, (j == 0) && !cont);
        made++;
      end
    end
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (lis_pending.size() != 0 || in_ch.valid || lis_expected.size() != 0);
  endtask

  always @(negedge clk) begin : drive_input
    lis_item_t nxt;
    int idle_pct;
    idle_pct = (cur_phase == PH_SRC_IDLE) ? 60 : (cur_phase == PH_BOTH_IDLE) ? 38 : 0;
    if (!in_ch.valid || in_took) begin
      if (lis_pending.size() != 0 && !(int'($urandom_range(99)) < idle_pct)) begin
        nxt = lis_pending.pop_front();
        in_ch.valid          <= 1'b1;
        in_ch.sample_value   <= nxt.sample_value;
        in_ch.start_sequence <= nxt.start_sequence;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    int stall_pct;
    stall_pct = (cur_phase == PH_SNK_STALL) ? 60 : (cur_phase == PH_BOTH_IDLE) ? 38 : 0;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (cur_phase == PH_HOLD && hold_cycles < HOLD_CYCLES) begin
      // long hold-off so the block backs up and stalls its input
      out_ch.ready <= 1'b0;
      hold_cycles  <= hold_cycles + 1;
    end else begin
      out_ch.ready <= !(int'($urandom_range(99)) < stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    lis_result_t exp_r;
    lis_result_t pred;
    in_took <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (lis_expected.size() == 0) begin
          $error("unexpected result transfer: run_length %0d position %0d overflow %0d",
                 out_ch.run_length, out_ch.position, out_ch.overflow);
          mismatches++;
        end else begin
          exp_r = lis_expected.pop_front();
          if (out_ch.run_length !== exp_r.run_length) begin
            $error("run_length: expected %0d, got %0d", exp_r.run_length, out_ch.run_length);
            mismatches++;
          end
          if (out_ch.position !== exp_r.position) begin
            $error("position: expected %0d, got %0d", exp_r.position, out_ch.position);
            mismatches++;
          end
          if (out_ch.overflow !== exp_r.overflow) begin
            $error("overflow: expected %0d, got %0d", exp_r.overflow, out_ch.overflow);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_lis_step(in_ch.sample_value, in_ch.start_sequence, pred);
        lis_expected.push_back(pred);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int i;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.sample_value   = '0;
    in_ch.start_sequence = 1'b0;
    out_ch.ready         = 1'b0;
    in_took              = 1'b0;
    hold_cycles          = 0;
    stall_cycles         = 0;
    mismatches           = 0;
    gen_count            = 0;
    seq_count            = 0;
    cur_phase            = PH_NO_IDLE;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: first item without a start flag, extremes, ties, runs both ways
    queue_item(32'd5, 1'b0);
    queue_item(VAL_MIN, 1'b1);
    queue_item(VAL_MAX, 1'b0);
    queue_item(32'd0, 1'b0);
    queue_item(32'hffff_ffff, 1'b0);
    queue_item(32'd1, 1'b0);
    queue_item(32'd1, 1'b0);
    queue_item(VAL_MAX, 1'b0);
    queue_item(VAL_MIN, 1'b0);
    queue_item(32'd3, 1'b1);
    queue_item(32'd2, 1'b0);
    queue_item(32'd1, 1'b0);
    for (i = 0; i < 5; i++) queue_item(i - 3, i == 0);
    queue_item(32'h5555_5555, 1'b1);
    queue_item(32'haaaa_aaaa, 1'b1);
    wait_drained();

    // long strictly increasing run, a random tail, then restart
    for (i = 0; i < LONG_RUN; i++)
      queue_item(VAL_MIN + i * 32'h0140_0000 + $urandom_range(32'h013f_ffff), i == 0);
    for (i = 0; i < 3; i++) queue_item($urandom, 1'b0);
    queue_item($urandom, 1'b1);
    wait_drained();

    cur_phase = PH_NO_IDLE;
    queue_random_sequences(PHASE_ITEMS);
    wait_drained();
    cur_phase = PH_SRC_IDLE;
    queue_random_sequences(PHASE_ITEMS);
    wait_drained();
    cur_phase = PH_SNK_STALL;
    queue_random_sequences(PHASE_ITEMS);
    wait_drained();
    cur_phase = PH_BOTH_IDLE;
    queue_random_sequences(PHASE_ITEMS);
    wait_drained();
    cur_phase = PH_HOLD;
    queue_random_sequences(PHASE_ITEMS);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && lis_expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
